// ===== rtl/gdsc_pkg.sv =====
package gdsc_pkg;

	// Operation selector codes.
	localparam logic [1:0] OP_TO_SERIAL = 2'd0;
	localparam logic [1:0] OP_TO_DATE   = 2'd1;
	localparam logic [1:0] OP_PREV_DATE = 2'd2;
	localparam logic [1:0] OP_NONE      = 2'd3;

	// Error codes.
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_DATE  = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;

	// Cycle lengths of the calendar in days.
	localparam int unsigned DAYS_400 = 146097;
	localparam int unsigned DAYS_100 = 36524;
	localparam int unsigned DAYS_4   = 1461;
	localparam int unsigned DAYS_1   = 365;

	// Side data that rides along the conversion stages.
	typedef struct packed {
		logic        conv;
		logic [1:0]  err;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [21:0] serial;
	} gdsc_side_t;

	// Length of a month in a common year; zero for a month code that is not a month.
	function automatic logic [4:0] month_days(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd1:    len = 5'd31;
			4'd2:    len = 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// Days of the year that come before the first of month m.
	function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
		logic [8:0] base;
		case (m)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && (m > 4'd2)) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

// ===== rtl/gregorian_date_serial_convert_unit.sv =====
// Proleptic Gregorian date and serial day number converter. A word is taken at every clock
// edge where start is high; busy stays low because the pipeline never stalls. The result of a
// word is driven on the result ports with done high for exactly one cycle, from the registers
// of the last stage. The receiver cannot hold a result off, so it must capture every word that
// done marks. One word per cycle is sustained.
// The eleven stages are set by the serial-to-date path: a reciprocal multiply and a subtract
// for the 400-year cycle, compares for the century, a reciprocal multiply and a subtract for
// the four-year group, compares for the year, then the month search and the day of the month.
// A word with op 3 is taken but gives no result. There is no clearing pass after reset.
module gregorian_date_serial_convert_unit #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [4:0]  day,
	input  logic [3:0]  month,
	input  logic [13:0] year,
	input  logic [21:0] serial_in,
	output logic        done,
	output logic [4:0]  day_out,
	output logic [3:0]  month_out,
	output logic [13:0] year_out,
	output logic [21:0] serial_out,
	output logic [1:0]  error_code
);
	import gdsc_pkg::*;

	localparam int unsigned Latency = 11;
	localparam logic [16:0] MaxYear = 17'(MAX_YEAR);
	localparam logic [24:0] SerialMax =
		25'(365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400);
	// Reciprocals, exact over the operand ranges that reach them.
	localparam logic [12:0] Recip100 = 13'd5243;
	localparam logic [23:0] Recip400 = 24'((64'd1 << 41) / 64'(DAYS_400) + 64'd1);
	localparam logic [21:0] Recip4   = 22'((64'd1 << 32) / 64'(DAYS_4) + 64'd1);

	logic accept;

	// Stage registers.
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic [1:0]  op_s1, op_s2, op_s3;
	logic [4:0]  day_s1, day_s2, day_s3;
	logic [3:0]  month_s1, month_s2, month_s3;
	logic [13:0] year_s1, year_s2, year_s3;
	logic [21:0] serial_s1, serial_s2, serial_s3;
	logic [22:0] mul365_s2;
	logic [11:0] dq4_s2;
	logic [7:0]  dq100_s2, yq100_s2;
	logic [5:0]  dq400_s2, yq400_s2;
	logic        range_bad_s2, range_bad_s3;
	logic        date_ok_s3;
	logic [22:0] sdate_s3;
	gdsc_side_t  side_s4, side_s5, side_s6, side_s7, side_s8, side_s9, side_s10;
	logic [22:0] n_s4;
	logic [5:0]  q400_s4, q400_s5, q400_s6, q400_s7, q400_s8;
	logic [17:0] r400_s5;
	logic [1:0]  q100_s6, q100_s7, q100_s8;
	logic [15:0] r100_s6, r100_s7;
	logic [4:0]  q4_s7, q4_s8;
	logic [10:0] r4_s8;
	logic [8:0]  r1_s9, r1_s10;
	logic        leap_s9, leap_s10;
	logic [13:0] yr_s9, yr_s10;
	logic [3:0]  mon_s10;
	logic [4:0]  day_s11;
	logic [3:0]  month_s11;
	logic [13:0] year_s11;
	logic [21:0] serial_s11;
	logic [1:0]  err_s11;

	// Combinational values of each stage.
	logic [13:0] dy2;
	logic [22:0] mul365_2;
	logic [26:0] dprod100_2, yprod100_2;
	logic [24:0] dprod400_2, yprod400_2;
	logic        range_bad_2;
	logic        leap3, date_ok3;
	logic [4:0]  mlen3;
	logic [22:0] sdate3;
	logic [1:0]  err4;
	logic [22:0] sres4, n4;
	logic [46:0] prod400_4;
	gdsc_side_t  side4;
	logic [22:0] r400_5;
	logic [1:0]  q100_6;
	logic [17:0] r100_6;
	logic [37:0] prod4_7;
	logic [15:0] r4_8;
	logic [1:0]  q1_9;
	logic [10:0] r1_9;
	logic        leap9;
	logic [15:0] yr9;
	logic [3:0]  mon10;
	logic [8:0]  day11;

	// The pipeline never holds off a word.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Valid bits travel with the words; op 3 produces nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			v_s1  <= accept && (op != OP_NONE);
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// Stage 2: products for the days before the year, year quotients for the leap rule.
	always_comb begin
		dy2         = year_s1 - 14'd1;
		mul365_2    = 23'(dy2) * 23'(DAYS_1);
		dprod100_2  = 27'(dy2) * 27'(Recip100);
		dprod400_2  = 25'(dy2[13:2]) * 25'(Recip100);
		yprod100_2  = 27'(year_s1) * 27'(Recip100);
		yprod400_2  = 25'(year_s1[13:2]) * 25'(Recip100);
		range_bad_2 = (serial_s1 == 22'd0) || ({3'b000, serial_s1} > SerialMax);
	end

	// Stage 3: leap rule, date check and the serial number of the date.
	always_comb begin
		leap3 = ((year_s2[1:0] == 2'd0) && (year_s2 != 14'(yq100_s2) * 14'd100))
			|| (year_s2 == 14'(yq400_s2) * 14'd400);
		mlen3 = ((month_s2 == 4'd2) && leap3) ? 5'd29 : month_days(month_s2);
		date_ok3 = (year_s2 != 14'd0) && ({3'b000, year_s2} <= MaxYear)
			&& (month_s2 >= 4'd1) && (month_s2 <= 4'd12)
			&& (day_s2 != 5'd0) && (day_s2 <= mlen3);
		sdate3 = mul365_s2 + 23'(dq4_s2) + 23'(dq400_s2) - 23'(dq100_s2)
			+ 23'(cum_days(month_s2, leap3)) + 23'(day_s2);
	end

	// Stage 4: pick the serial to convert, settle the error code, estimate the 400-year count.
	always_comb begin
		case (op_s3)
			OP_TO_SERIAL: begin
				err4  = date_ok_s3 ? ERR_NONE : ERR_DATE;
				sres4 = sdate_s3;
				n4    = sdate_s3 - 23'd1;
			end
			OP_TO_DATE: begin
				err4  = range_bad_s3 ? ERR_RANGE : ERR_NONE;
				sres4 = {1'b0, serial_s3};
				n4    = {1'b0, serial_s3} - 23'd1;
			end
			default: begin
				if (!date_ok_s3) begin
					err4 = ERR_DATE;
				end else if (sdate_s3 <= 23'd1) begin
					err4 = ERR_RANGE;
				end else begin
					err4 = ERR_NONE;
				end
				sres4 = sdate_s3 - 23'd1;
				n4    = sdate_s3 - 23'd2;
			end
		endcase
		prod400_4    = 47'(n4) * 47'(Recip400);
		side4.conv   = (op_s3 != OP_TO_SERIAL);
		side4.err    = err4;
		side4.day    = day_s3;
		side4.month  = month_s3;
		side4.year   = year_s3;
		side4.serial = sres4[21:0];
	end

	// Stage 5: remainder within the 400-year cycle.
	assign r400_5 = n_s4 - 23'(q400_s4) * 23'(DAYS_400);

	// Stage 6: century within the cycle, the last century taking the extra day.
	always_comb begin
		q100_6 = 2'(r400_s5 >= 18'(DAYS_100)) + 2'(r400_s5 >= 18'(2 * DAYS_100))
			+ 2'(r400_s5 >= 18'(3 * DAYS_100));
		r100_6 = r400_s5 - 18'(q100_6) * 18'(DAYS_100);
	end

	// Stage 7: four-year group within the century.
	assign prod4_7 = 38'(r100_s6) * 38'(Recip4);

	// Stage 8: remainder within the four-year group.
	assign r4_8 = r100_s7 - 16'(q4_s7) * 16'(DAYS_4);

	// Stage 9: year within the group, its leap flag and the full year.
	always_comb begin
		q1_9 = 2'(r4_s8 >= 11'(DAYS_1)) + 2'(r4_s8 >= 11'(2 * DAYS_1))
			+ 2'(r4_s8 >= 11'(3 * DAYS_1));
		r1_9 = r4_s8 - 11'(q1_9) * 11'(DAYS_1);
		leap9 = (q1_9 == 2'd3) && !((q4_s8 == 5'd24) && (q100_s8 != 2'd3));
		yr9 = 16'(q400_s8) * 16'd400 + 16'(q100_s8) * 16'd100 + 16'(q4_s8) * 16'd4
			+ 16'(q1_9) + 16'd1;
	end

	// Stage 10: month search over the day of the year.
	always_comb begin
		mon10 = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			if (r1_s9 >= cum_days(4'(k), leap_s9)) begin
				mon10 = mon10 + 4'd1;
			end
		end
	end

	// Stage 11: day of the month.
	assign day11 = r1_s10 - cum_days(mon_s10, leap_s10) + 9'd1;

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		op_s1     <= op;
		day_s1    <= day;
		month_s1  <= month;
		year_s1   <= year;
		serial_s1 <= serial_in;

		op_s2        <= op_s1;
		day_s2       <= day_s1;
		month_s2     <= month_s1;
		year_s2      <= year_s1;
		serial_s2    <= serial_s1;
		mul365_s2    <= mul365_2;
		dq4_s2       <= dy2[13:2];
		dq100_s2     <= dprod100_2[26:19];
		dq400_s2     <= dprod400_2[24:19];
		yq100_s2     <= yprod100_2[26:19];
		yq400_s2     <= yprod400_2[24:19];
		range_bad_s2 <= range_bad_2;

		op_s3        <= op_s2;
		day_s3       <= day_s2;
		month_s3     <= month_s2;
		year_s3      <= year_s2;
		serial_s3    <= serial_s2;
		range_bad_s3 <= range_bad_s2;
		date_ok_s3   <= date_ok3;
		sdate_s3     <= sdate3;

		side_s4 <= side4;
		n_s4    <= n4;
		q400_s4 <= prod400_4[46:41];

		side_s5 <= side_s4;
		q400_s5 <= q400_s4;
		r400_s5 <= r400_5[17:0];

		side_s6 <= side_s5;
		q400_s6 <= q400_s5;
		q100_s6 <= q100_6;
		r100_s6 <= r100_6[15:0];

		side_s7 <= side_s6;
		q400_s7 <= q400_s6;
		q100_s7 <= q100_s6;
		r100_s7 <= r100_s6;
		q4_s7   <= prod4_7[36:32];

		side_s8 <= side_s7;
		q400_s8 <= q400_s7;
		q100_s8 <= q100_s7;
		q4_s8   <= q4_s7;
		r4_s8   <= r4_8[10:0];

		side_s9 <= side_s8;
		r1_s9   <= r1_9[8:0];
		leap_s9 <= leap9;
		yr_s9   <= yr9[13:0];

		side_s10 <= side_s9;
		r1_s10   <= r1_s9;
		leap_s10 <= leap_s9;
		yr_s10   <= yr_s9;
		mon_s10  <= mon10;

		// Result word: zeros on error, the input date for op 0, else the converted date.
		err_s11 <= side_s10.err;
		if (side_s10.err != ERR_NONE) begin
			day_s11    <= 5'd0;
			month_s11  <= 4'd0;
			year_s11   <= 14'd0;
			serial_s11 <= 22'd0;
		end else if (!side_s10.conv) begin
			day_s11    <= side_s10.day;
			month_s11  <= side_s10.month;
			year_s11   <= side_s10.year;
			serial_s11 <= side_s10.serial;
		end else begin
			day_s11    <= day11[4:0];
			month_s11  <= mon_s10;
			year_s11   <= yr_s10;
			serial_s11 <= side_s10.serial;
		end
	end

	assign done       = v_s11;
	assign day_out    = day_s11;
	assign month_out  = month_s11;
	assign year_out   = year_s11;
	assign serial_out = serial_s11;
	assign error_code = err_s11;

`ifndef SYNTHESIS
	// Every word with a defined op gives a result after the fixed latency.
	a_latency_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op != OP_NONE)) |-> ##Latency done)
		else $error("result missing after an accepted word");

	// No result appears without a word that asked for it.
	a_latency_miss: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && (op != OP_NONE)) |-> ##Latency !done)
		else $error("result without an accepted word");

	// A failed word carries an all-zero date and serial.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (error_code != ERR_NONE)) |->
		((day_out == 5'd0) && (month_out == 4'd0) && (year_out == 14'd0)
		&& (serial_out == 22'd0)))
		else $error("error result with nonzero fields");

	// A good result holds a real month and day.
	a_date_sane: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (error_code == ERR_NONE)) |->
		((month_out >= 4'd1) && (month_out <= 4'd12) && (day_out >= 5'd1)
		&& (year_out != 14'd0)))
		else $error("good result with a malformed date");
`endif

endmodule

// ===== dv/gregorian_date_serial_convert_unit_tb.sv =====
`timescale 1ns / 1ps

module gregorian_date_serial_convert_unit_tb;
	import gdsc_pkg::*;

	localparam int unsigned LAST_YEAR = 9999;
	localparam int unsigned LAST_SERIAL = 3652059;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int TAIL_CYCLES = 30;

	// One result word as the block reports it.
	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [21:0] serial;
		logic [1:0]  err;
	} calendar_word_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  op;
	logic [4:0]  day;
	logic [3:0]  month;
	logic [13:0] year;
	logic [21:0] serial_in;
	logic        done;
	logic [4:0]  day_out;
	logic [3:0]  month_out;
	logic [13:0] year_out;
	logic [21:0] serial_out;
	logic [1:0]  error_code;

	calendar_word_t pending_dates[$];
	int mismatch_count = 0;
	int stall_cycles = 0;
	int sender_idle_pct = 0;

	gregorian_date_serial_convert_unit #(
		.MAX_YEAR(LAST_YEAR)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.day(day),
		.month(month),
		.year(year),
		.serial_in(serial_in),
		.done(done),
		.day_out(day_out),
		.month_out(month_out),
		.year_out(year_out),
		.serial_out(serial_out),
		.error_code(error_code)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Calendar arithmetic used to predict each result.
	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
		int unsigned len;
		case (m)
			2:       len = leap_year(y) ? 29 : 28;
			4, 6, 9, 11: len = 30;
			default: len = 31;
		endcase
		return len;
	endfunction

	function automatic int unsigned days_ahead_of_year(input int unsigned y);
		int unsigned n;
		n = y - 1;
		return 365 * n + n / 4 - n / 100 + n / 400;
	endfunction

	function automatic bit date_ok(input int unsigned d, input int unsigned m,
			input int unsigned y);
		if (y < 1 || y > LAST_YEAR) begin
			return 1'b0;
		end
		if (m < 1 || m > 12) begin
			return 1'b0;
		end
		return (d >= 1) && (d <= month_length(m, y));
	endfunction

	function automatic int unsigned serial_of(input int unsigned d, input int unsigned m,
			input int unsigned y);
		int unsigned s;
		s = days_ahead_of_year(y);
		for (int unsigned i = 1; i < m; i++) begin
			s += month_length(i, y);
		end
		return s + d;
	endfunction

	// Splits a serial into 400, 100, 4 and 1 year cycles, then walks the months.
	function automatic void date_of(input int unsigned s, output int unsigned d,
			output int unsigned m, output int unsigned y);
		int unsigned n, r, q400, q100, q4, q1;
		n = s - 1;
		q400 = n / 146097;
		r = n % 146097;
		q100 = r / 36524;
		if (q100 > 3) begin
			q100 = 3;
		end
		r -= q100 * 36524;
		q4 = r / 1461;
		r %= 1461;
		q1 = r / 365;
		if (q1 > 3) begin
			q1 = 3;
		end
		r -= q1 * 365;
		y = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
		m = 1;
		while (m < 12 && r >= month_length(m, y)) begin
			r -= month_length(m, y);
			m++;
		end
		d = r + 1;
	endfunction

	function automatic calendar_word_t predict_word(input logic [1:0] w_op,
			input int unsigned d, input int unsigned m, input int unsigned y,
			input int unsigned s);
		calendar_word_t w;
		int unsigned rd, rm, ry, rs;
		w = '0;
		case (w_op)
			OP_TO_SERIAL: begin
				if (!date_ok(d, m, y)) begin
					w.err = ERR_DATE;
				end else begin
					w.day = 5'(d);
					w.month = 4'(m);
					w.year = 14'(y);
					w.serial = 22'(serial_of(d, m, y));
					w.err = ERR_NONE;
				end
			end
			OP_TO_DATE: begin
				if (s < 1 || s > LAST_SERIAL) begin
					w.err = ERR_RANGE;
				end else begin
					date_of(s, rd, rm, ry);
					w.day = 5'(rd);
					w.month = 4'(rm);
					w.year = 14'(ry);
					w.serial = 22'(s);
					w.err = ERR_NONE;
				end
			end
			default: begin
				if (!date_ok(d, m, y)) begin
					w.err = ERR_DATE;
				end else begin
					rs = serial_of(d, m, y);
					if (rs <= 1) begin
						w.err = ERR_RANGE;
					end else begin
						rs -= 1;
						date_of(rs, rd, rm, ry);
						w.day = 5'(rd);
						w.month = 4'(rm);
						w.year = 14'(ry);
						w.serial = 22'(rs);
						w.err = ERR_NONE;
					end
				end
			end
		endcase
		return w;
	endfunction

	// Mismatch reporting.
	task automatic report_mismatch(input string msg);
		$display("%0t: MISMATCH %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want) begin
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	// Result checker: every strobed word is compared with the oldest prediction.
	always @(posedge clk) begin
		calendar_word_t want;
		if (arst_n && done) begin
			if (pending_dates.size() == 0) begin
				report_mismatch($sformatf("unexpected word %0d/%0d/%0d serial %0d err %0d",
					day_out, month_out, year_out, serial_out, error_code));
			end else begin
				want = pending_dates.pop_front();
				check_field("day_out", 32'(day_out), 32'(want.day));
				check_field("month_out", 32'(month_out), 32'(want.month));
				check_field("year_out", 32'(year_out), 32'(want.year));
				check_field("serial_out", 32'(serial_out), 32'(want.serial));
				check_field("error_code", 32'(error_code), 32'(want.err));
			end
		end
	end

	// Watchdog on cycles where no word moves in either direction.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Sends one word, waits for it to be taken, records its prediction, then maybe idles.
	task automatic send_word(input logic [1:0] w_op, input int unsigned w_day,
			input int unsigned w_month, input int unsigned w_year,
			input int unsigned w_serial);
		logic [4:0]  f_day;
		logic [3:0]  f_month;
		logic [13:0] f_year;
		logic [21:0] f_serial;
		f_day = 5'(w_day);
		f_month = 4'(w_month);
		f_year = 14'(w_year);
		f_serial = 22'(w_serial);
		start <= 1'b1;
		op <= w_op;
		day <= f_day;
		month <= f_month;
		year <= f_year;
		serial_in <= f_serial;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		if (w_op != OP_NONE) begin
			pending_dates.push_back(predict_word(w_op, 32'(f_day), 32'(f_month),
				32'(f_year), 32'(f_serial)));
		end
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Holds the sender off until every predicted word has come back.
	task automatic wait_for_results();
		start <= 1'b0;
		while (pending_dates.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic test_reset();
		arst_n <= 1'b0;
		start <= 1'b0;
		op <= OP_TO_SERIAL;
		day <= '0;
		month <= '0;
		year <= '0;
		serial_in <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// Date to serial at the calendar ends, leap rules and invalid fields.
	task automatic test_date_to_serial_edges();
		send_word(OP_TO_SERIAL, 1, 1, 1, $urandom);
		send_word(OP_TO_SERIAL, 31, 12, 9999, $urandom);
		send_word(OP_TO_SERIAL, 29, 2, 2000, $urandom);
		send_word(OP_TO_SERIAL, 29, 2, 1900, $urandom);
		send_word(OP_TO_SERIAL, 0, 5, 10, $urandom);
		send_word(OP_TO_SERIAL, 31, 4, 2021, $urandom);
		send_word(OP_TO_SERIAL, 1, 0, 5, $urandom);
		send_word(OP_TO_SERIAL, 1, 15, 5, $urandom);
		send_word(OP_TO_SERIAL, 1, 1, 0, $urandom);
		send_word(OP_TO_SERIAL, 1, 1, 10000, $urandom);
		send_word(OP_TO_SERIAL, 31, 15, 16383, 4194303);
	endtask

	// Serial to date at zero, at the cycle ends and past the last day.
	task automatic test_serial_to_date_edges();
		send_word(OP_TO_DATE, $urandom, $urandom, $urandom, 0);
		send_word(OP_TO_DATE, $urandom, $urandom, $urandom, 1);
		send_word(OP_TO_DATE, $urandom, $urandom, $urandom, 1461);
		send_word(OP_TO_DATE, $urandom, $urandom, $urandom, 36524);
		send_word(OP_TO_DATE, $urandom, $urandom, $urandom, 146097);
		send_word(OP_TO_DATE, $urandom, $urandom, $urandom, LAST_SERIAL);
		send_word(OP_TO_DATE, $urandom, $urandom, $urandom, LAST_SERIAL + 1);
		send_word(OP_TO_DATE, $urandom, $urandom, $urandom, 4194303);
	endtask

	// Previous date across month and year ends, the first day, and a bad date.
	task automatic test_prev_date_edges();
		send_word(OP_PREV_DATE, 1, 1, 1, $urandom);
		send_word(OP_PREV_DATE, 2, 1, 1, $urandom);
		send_word(OP_PREV_DATE, 1, 3, 2000, $urandom);
		send_word(OP_PREV_DATE, 1, 1, 2001, $urandom);
		send_word(OP_PREV_DATE, 30, 2, 2000, $urandom);
	endtask

	// The spare selector is taken but yields nothing.
	task automatic test_ignored_op();
		send_word(OP_NONE, 31, 15, 16383, 4194303);
	endtask

	function automatic int unsigned pick_year();
		int unsigned picks[11] = '{1, 2, 4, 100, 399, 400, 1600, 1900, 2000, 9996, 9999};
		int unsigned y;
		case ($urandom_range(9))
			0:       y = picks[$urandom_range(10)];
			1:       y = 100 * $urandom_range(99, 1);
			2:       y = 4 * $urandom_range(2499, 1);
			default: y = $urandom_range(LAST_YEAR, 1);
		endcase
		return y;
	endfunction

	// Mostly well-formed words with random content, the rest raw noise.
	task automatic test_random_traffic(input int idle_pct, input int count);
		int unsigned d, m, y, s;
		logic [1:0] w_op;
		sender_idle_pct = idle_pct;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) begin
				wait_for_results();
			end
			if ($urandom_range(99) < 15) begin
				send_word(2'($urandom), $urandom, $urandom, $urandom, $urandom);
			end else begin
				w_op = 2'($urandom_range(2));
				y = pick_year();
				m = $urandom_range(12, 1);
				case ($urandom_range(3))
					0:       d = 1;
					1:       d = month_length(m, y);
					default: d = $urandom_range(month_length(m, y), 1);
				endcase
				case ($urandom_range(3))
					0:       s = serial_of(d, m, y);
					1:       s = 146097 * $urandom_range(24) + $urandom_range(4) + 1;
					default: s = $urandom_range(LAST_SERIAL, 1);
				endcase
				if (s > LAST_SERIAL) begin
					s = LAST_SERIAL;
				end
				send_word(w_op, d, m, y, s);
			end
		end
	endtask

	// Test sequence.
	initial begin
		test_reset();
		sender_idle_pct = 21;
		test_date_to_serial_edges();
		test_serial_to_date_edges();
		test_prev_date_edges();
		test_ignored_op();
		test_random_traffic(21, 630);
		test_random_traffic(60, 630);
		test_random_traffic(0, 640);
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== gregorian_date_serial_convert_unit.f =====
rtl/gdsc_pkg.sv
rtl/gregorian_date_serial_convert_unit.sv
dv/gregorian_date_serial_convert_unit_tb.sv
